// File: src/tns_pkg.sv
// Shared types, codes and the note period table of the tone note sequencer.
package tns_pkg;

  // Request kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_NOTE  = 2'd1,
    MODE_SCALE = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  // Playback state, one-hot.
  typedef enum logic [2:0] {
    PLAY_IDLE   = 3'b001,
    PLAY_SINGLE = 3'b010,
    PLAY_SERIES = 3'b100
  } play_t;

  // Codes shown on the play_state result field.
  localparam logic [1:0] PS_IDLE   = 2'd0;
  localparam logic [1:0] PS_SINGLE = 2'd1;
  localparam logic [1:0] PS_SCALE  = 2'd2;

  localparam int unsigned NUM_OCTAVES = 9;
  localparam int unsigned NUM_NOTES   = 7;
  localparam logic [2:0]  MAX_NOTE    = 3'd6;
  localparam logic [3:0]  MAX_OCTAVE  = 4'd8;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // One request as it arrives on the input channel.
  typedef struct packed {
    mode_t       mode;
    logic [2:0]  note;
    logic [3:0]  octave;
    logic [15:0] note_ticks;
  } in_t;

  // One result item.
  typedef struct packed {
    logic        tone_on;
    logic [12:0] period;
    logic [11:0] compare;
    logic [1:0]  play_state;
    logic [2:0]  scale_step;
    logic        rejected;
  } out_t;

  // PWM auto-reload values, one row per octave, Do..Si along each row.
  localparam logic [12:0] PERIOD_TBL [NUM_OCTAVES][NUM_NOTES] = '{
    '{13'd8164, 13'd7273, 13'd6477, 13'd6101, 13'd5433, 13'd4840, 13'd4314},
    '{13'd4082, 13'd3636, 13'd3238, 13'd3050, 13'd2716, 13'd2420, 13'd2157},
    '{13'd2040, 13'd1817, 13'd1618, 13'd1524, 13'd1357, 13'd1209, 13'd1077},
    '{13'd1020, 13'd908,  13'd808,  13'd762,  13'd678,  13'd604,  13'd538},
    '{13'd510,  13'd454,  13'd404,  13'd381,  13'd339,  13'd302,  13'd270},
    '{13'd254,  13'd226,  13'd201,  13'd190,  13'd169,  13'd150,  13'd134},
    '{13'd126,  13'd112,  13'd100,  13'd94,   13'd84,   13'd75,   13'd67},
    '{13'd62,   13'd56,   13'd49,   13'd46,   13'd41,   13'd37,   13'd33},
    '{13'd30,   13'd27,   13'd24,   13'd23,   13'd20,   13'd18,   13'd16}
  };

  // Period of one note; zero for a note or octave outside the table.
  function automatic logic [12:0] period_lookup(input logic [3:0] oct,
                                                input logic [2:0] nt);
    logic [12:0] val;
    val = 13'd0;
    if (oct <= MAX_OCTAVE && nt <= MAX_NOTE) begin
      val = PERIOD_TBL[oct][nt];
    end
    return val;
  endfunction

endpackage

// File: src/tns_core.sv
// Playback state registers and the per-request update logic of the sequencer.
module tns_core import tns_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  in_t  req,
  output out_t res
);

  play_t       play_r, play_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] note_len_r, note_len_nxt;
  logic [3:0]  sc_oct_r, sc_oct_nxt;
  logic [2:0]  sc_idx_r, sc_idx_nxt;
  logic [12:0] period_r, period_nxt;
  logic [15:0] elapsed_inc;
  logic        note_bad;
  logic        oct_bad;
  logic        rejected;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 16'd1;
  assign note_bad    = req.note > MAX_NOTE;
  assign oct_bad     = req.octave > MAX_OCTAVE;

  // Next playback state for the request at hand.
  always_comb begin
    play_nxt     = play_r;
    elapsed_nxt  = elapsed_r;
    note_len_nxt = note_len_r;
    sc_oct_nxt   = sc_oct_r;
    sc_idx_nxt   = sc_idx_r;
    period_nxt   = period_r;
    rejected     = 1'b0;
    case (req.mode)
      MODE_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (play_r != PLAY_IDLE && elapsed_inc >= note_len_r) begin
          if (play_r == PLAY_SERIES && sc_idx_r < MAX_NOTE) begin
            // Move on to the next note of the scale.
            sc_idx_nxt  = sc_idx_r + 3'd1;
            period_nxt  = period_lookup(sc_oct_r, sc_idx_r + 3'd1);
            elapsed_nxt = 16'd0;
          end else begin
            play_nxt   = PLAY_IDLE;
            sc_idx_nxt = 3'd0;
          end
        end
      end
      MODE_NOTE: begin
        if (note_bad || oct_bad) begin
          rejected = 1'b1;
        end else begin
          period_nxt   = period_lookup(req.octave, req.note);
          play_nxt     = PLAY_SINGLE;
          sc_idx_nxt   = 3'd0;
          elapsed_nxt  = 16'd0;
          note_len_nxt = req.note_ticks;
        end
      end
      MODE_SCALE: begin
        if (oct_bad) begin
          rejected = 1'b1;
        end else begin
          sc_oct_nxt   = req.octave;
          sc_idx_nxt   = 3'd0;
          note_len_nxt = req.note_ticks;
          period_nxt   = period_lookup(req.octave, 3'd0);
          play_nxt     = PLAY_SERIES;
          elapsed_nxt  = 16'd0;
        end
      end
      default: begin
        // Stop request.
        play_nxt   = PLAY_IDLE;
        sc_idx_nxt = 3'd0;
      end
    endcase
  end

  // Result fields follow the state as it stands after this request.
  always_comb begin
    res.tone_on    = (play_nxt != PLAY_IDLE);
    res.period     = period_nxt;
    res.compare    = period_nxt[12:1];
    res.rejected   = rejected;
    res.scale_step = 3'd0;
    case (play_nxt)
      PLAY_SINGLE: res.play_state = PS_SINGLE;
      PLAY_SERIES: begin
        res.play_state = PS_SCALE;
        res.scale_step = sc_idx_nxt;
      end
      default: res.play_state = PS_IDLE;
    endcase
  end

  // State registers advance once per processed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r     <= PLAY_IDLE;
      elapsed_r  <= 16'd0;
      note_len_r <= 16'd0;
      sc_oct_r   <= 4'd0;
      sc_idx_r   <= 3'd0;
      period_r   <= 13'd0;
    end else if (fire) begin
      play_r     <= play_nxt;
      elapsed_r  <= elapsed_nxt;
      note_len_r <= note_len_nxt;
      sc_oct_r   <= sc_oct_nxt;
      sc_idx_r   <= sc_idx_nxt;
      period_r   <= period_nxt;
    end
  end

endmodule

// File: src/tone_note_sequencer_unit.sv
// Top level of the tone note sequencer: input register, update logic, result register.
//
// Buzzer tone sequencer. Each request is a one-millisecond tick, a play-note,
// a play-scale or a stop. Every request yields exactly one result with the
// buzzer enable, the PWM period and half-period compare, the playback state,
// the scale step and a flag for a refused request. The block takes one request
// per clock cycle while the output side does not stall; a request is held in
// the input register, and its result is then presented from the result
// register. Both registers hold while the output side stalls, and the input
// side keeps taking requests as long as either register has room.
module tone_note_sequencer_unit import tns_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  in_t  req_r;
  logic req_vld_r;
  out_t res_r;
  logic out_vld_r;
  out_t res;
  logic out_load;
  logic fire;

  // A held request moves to the result register whenever that register frees up.
  assign out_load = !out_vld_r || out_ready;
  assign fire     = req_vld_r && out_load;
  assign in_ready = !req_vld_r || out_load;

  tns_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req_r),
    .res   (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = res_r;

  // A processed request always lands in the result register.
  a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed request did not reach the result register");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ready && !req_vld_r) |=> !out_vld_r)
    else $error("result shown twice");

  // Ticks and stops are never refused.
  a_no_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (req_r.mode == MODE_TICK || req_r.mode == MODE_STOP)) |=> !res_r.rejected)
    else $error("tick or stop flagged as rejected");

  // An idle result shows no tone and no scale step.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.play_state == PS_IDLE) |-> (!res_r.tone_on && res_r.scale_step == 3'd0))
    else $error("idle result with tone or scale step");

endmodule

// File: tb/tone_note_sequencer_checker.sv
`timescale 1ns / 100ps
// Result checker for the tone note sequencer: tracks playback, predicts each result, compares.
module tone_note_sequencer_checker import tns_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   refused_seen
);

  // PWM reload values per octave (rows) and note Do..Si (columns).
  localparam logic [12:0] NOTE_PERIODS [NUM_OCTAVES][NUM_NOTES] = '{
    '{13'd8164, 13'd7273, 13'd6477, 13'd6101, 13'd5433, 13'd4840, 13'd4314},
    '{13'd4082, 13'd3636, 13'd3238, 13'd3050, 13'd2716, 13'd2420, 13'd2157},
    '{13'd2040, 13'd1817, 13'd1618, 13'd1524, 13'd1357, 13'd1209, 13'd1077},
    '{13'd1020, 13'd908,  13'd808,  13'd762,  13'd678,  13'd604,  13'd538},
    '{13'd510,  13'd454,  13'd404,  13'd381,  13'd339,  13'd302,  13'd270},
    '{13'd254,  13'd226,  13'd201,  13'd190,  13'd169,  13'd150,  13'd134},
    '{13'd126,  13'd112,  13'd100,  13'd94,   13'd84,   13'd75,   13'd67},
    '{13'd62,   13'd56,   13'd49,   13'd46,   13'd41,   13'd37,   13'd33},
    '{13'd30,   13'd27,   13'd24,   13'd23,   13'd20,   13'd18,   13'd16}
  };

  // Shadow copy of the playback state.
  logic [1:0]  tone_mode;
  logic [15:0] ms_elapsed;
  logic [15:0] note_len;
  logic [3:0]  scale_oct;
  logic [2:0]  scale_pos;
  logic [12:0] cur_period;

  // Results still owed by the block, oldest first.
  out_t tone_results_due[$];

  function automatic logic [12:0] note_period(input logic [3:0] oct, input logic [2:0] nt);
    logic [12:0] val;
    val = '0;
    if (oct <= MAX_OCTAVE && nt <= MAX_NOTE) begin
      val = NOTE_PERIODS[oct][nt];
    end
    return val;
  endfunction

  function automatic void stop_playback();
    tone_mode = PS_IDLE;
    scale_pos = '0;
  endfunction

  // Apply one request to the shadow state and return the result it should produce.
  function automatic out_t advance_tone(input in_t req);
    out_t res;
    logic refused;
    refused = 1'b0;
    case (req.mode)
      MODE_TICK: begin
        if (ms_elapsed != ELAPSED_MAX) begin
          ms_elapsed = ms_elapsed + 16'd1;
        end
        if (tone_mode == PS_SINGLE && ms_elapsed >= note_len) begin
          stop_playback();
        end else if (tone_mode == PS_SCALE && ms_elapsed >= note_len) begin
          // The scale ends after its last note, otherwise it moves on.
          if (scale_pos >= MAX_NOTE) begin
            stop_playback();
          end else begin
            scale_pos  = scale_pos + 3'd1;
            cur_period = note_period(scale_oct, scale_pos);
            ms_elapsed = '0;
          end
        end
      end
      MODE_NOTE: begin
        if (req.note > MAX_NOTE || req.octave > MAX_OCTAVE) begin
          refused = 1'b1;
        end else begin
          cur_period = note_period(req.octave, req.note);
          tone_mode  = PS_SINGLE;
          scale_pos  = '0;
          ms_elapsed = '0;
          note_len   = req.note_ticks;
        end
      end
      MODE_SCALE: begin
        // The note field plays no part in a scale request.
        if (req.octave > MAX_OCTAVE) begin
          refused = 1'b1;
        end else begin
          scale_oct  = req.octave;
          scale_pos  = '0;
          note_len   = req.note_ticks;
          cur_period = note_period(req.octave, 3'd0);
          tone_mode  = PS_SCALE;
          ms_elapsed = '0;
        end
      end
      default: begin
        stop_playback();
      end
    endcase
    res.tone_on    = (tone_mode != PS_IDLE);
    res.period     = cur_period;
    res.compare    = cur_period[12:1];
    res.play_state = tone_mode;
    res.scale_step = (tone_mode == PS_SCALE) ? scale_pos : 3'd0;
    res.rejected   = refused;
    return res;
  endfunction

  task automatic check_field(input string fld, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Results are checked before the same edge's request is predicted.
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst_n) begin
      tone_mode    = PS_IDLE;
      ms_elapsed   = '0;
      note_len     = '0;
      scale_oct    = '0;
      scale_pos    = '0;
      cur_period   = '0;
      tone_results_due.delete();
      fail_count   = 0;
      results_seen = 0;
      refused_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (tone_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          exp_res = tone_results_due.pop_front();
          if (out_data.rejected) begin
            refused_seen++;
          end
          check_field("tone_on", 32'(exp_res.tone_on), 32'(out_data.tone_on));
          check_field("period", 32'(exp_res.period), 32'(out_data.period));
          check_field("compare", 32'(exp_res.compare), 32'(out_data.compare));
          check_field("play_state", 32'(exp_res.play_state), 32'(out_data.play_state));
          check_field("scale_step", 32'(exp_res.scale_step), 32'(out_data.scale_step));
          check_field("rejected", 32'(exp_res.rejected), 32'(out_data.rejected));
        end
      end
      if (in_valid && in_ready) begin
        tone_results_due.push_back(advance_tone(in_data));
      end
    end
    pending = tone_results_due.size();
  end

endmodule

// File: tb/tone_note_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// Top of the tone note sequencer testbench: clock, reset, request stimulus and verdict.
module tone_note_sequencer_unit_tb;
  import tns_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int fail_count;
  int pending;
  int results_seen;
  int refused_seen;

  int unsigned burst_left;
  int unsigned sent_total;
  int unsigned mode_count [4];
  int unsigned rx_left;
  int unsigned idle_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tone_note_sequencer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tone_note_sequencer_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .refused_seen (refused_seen)
  );

  // Result side: ready runs alternate with stalls, now and then a long ready stretch.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      if (out_ready) begin
        out_ready <= 1'b0;
        rx_left   <= $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b1;
        rx_left   <= ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
      end
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // Present one request and hold it until accepted; gaps fall between bursts.
  task automatic send_req(input mode_t m, input logic [2:0] nt, input logic [3:0] oct,
                          input logic [15:0] dur);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    in_valid         <= 1'b1;
    in_data.mode        <= m;
    in_data.note        <= nt;
    in_data.octave      <= oct;
    in_data.note_ticks  <= dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent_total++;
    mode_count[m]++;
  endtask

  // Ticks carry random content in the fields they do not use.
  task automatic send_ticks(input int unsigned count);
    repeat (count) begin
      send_req(MODE_TICK, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
               16'($urandom));
    end
  endtask

  task automatic send_noise();
    send_req(mode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
             4'($urandom_range(0, 15)), 16'($urandom));
  endtask

  // Ticks toward the end of a note or scale, with the odd stray request mixed in.
  task automatic play_out(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) begin
        send_noise();
      end else begin
        send_ticks(1);
      end
    end
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned dur;
    int unsigned kind;

    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick and stop, table corners, refused requests, zero durations.
    send_ticks(1);
    send_req(MODE_STOP, 3'd0, 4'd0, 16'd0);
    send_req(MODE_NOTE, 3'd0, 4'd0, 16'd2);
    send_ticks(1);
    send_req(MODE_NOTE, 3'd7, 4'd0, 16'd5);
    send_ticks(1);
    send_req(MODE_NOTE, 3'd6, 4'd8, 16'd0);
    send_ticks(1);
    send_req(MODE_NOTE, 3'd3, 4'd9, 16'd1);
    send_req(MODE_SCALE, 3'd0, 4'd15, 16'd1);
    send_req(MODE_SCALE, 3'd7, 4'd4, 16'd0);
    send_ticks(7);
    send_req(MODE_NOTE, 3'd3, 4'd2, 16'hFFFF);
    send_req(MODE_SCALE, 3'd2, 4'd8, 16'd1);
    send_ticks(1);
    send_req(MODE_STOP, 3'd7, 4'd15, 16'hFFFF);
    send_req(MODE_STOP, 3'd0, 4'd0, 16'd0);
    send_req(MODE_NOTE, 3'd7, 4'd15, 16'hFFFF);
    wait_drain();

    // Random: mostly complete notes and scales, plus stray and refused requests.
    random_start = sent_total;
    while (sent_total - random_start < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      dur  = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 3);
      if (kind <= 3) begin
        send_req(MODE_NOTE, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 8)), 16'(dur));
        play_out(dur + $urandom_range(0, 3));
      end else if (kind <= 6) begin
        dur = $urandom_range(0, 3);
        send_req(MODE_SCALE, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 8)), 16'(dur));
        play_out(7 * (dur + 1) + $urandom_range(0, 3));
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 5)) send_noise();
      end else if (kind == 8) begin
        case ($urandom_range(0, 2))
          0: send_req(MODE_NOTE, 3'd7, 4'($urandom_range(0, 15)), 16'($urandom));
          1: send_req(MODE_NOTE, 3'($urandom_range(0, 6)), 4'($urandom_range(9, 15)),
                      16'($urandom));
          default: send_req(MODE_SCALE, 3'($urandom_range(0, 7)),
                            4'($urandom_range(9, 15)), 16'($urandom));
        endcase
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          wait_drain();
        end
        send_req(MODE_STOP, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                 16'($urandom));
      end
    end
    wait_drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d requests: %0d ticks, %0d notes, %0d scales, %0d stops.",
             sent_total, mode_count[MODE_TICK], mode_count[MODE_NOTE],
             mode_count[MODE_SCALE], mode_count[MODE_STOP]);
    $display("Checked %0d results, %0d of them refused requests; %0d mismatches.",
             results_seen, refused_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: tone_note_sequencer_unit.f
src/tns_pkg.sv
src/tns_core.sv
src/tone_note_sequencer_unit.sv
tb/tone_note_sequencer_checker.sv
tb/tone_note_sequencer_unit_tb.sv
